@@ hw/rtl/csu_pkg.sv @@
package csu_pkg;

  localparam int unsigned ElemBits   = 16;
  localparam int unsigned AccBits    = 48;
  localparam int unsigned HalfBits   = AccBits / 2;
  localparam int unsigned ProdBits   = 2 * AccBits;
  localparam int unsigned QuotBits   = 31;
  localparam int unsigned RemBits    = ProdBits + QuotBits - 1;
  localparam int unsigned RootBits   = QuotBits - 1;
  localparam int unsigned SimBits    = 16;
  localparam int unsigned StepBits   = 5;
  localparam int unsigned MulSteps   = 8;
  localparam int unsigned DivSteps   = QuotBits;
  localparam int unsigned RootSteps  = RootBits / 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [ElemBits-1:0] elem_a;
    logic signed [ElemBits-1:0] elem_b;
    logic                       last;
  } in_req_t;

  typedef struct packed {
    logic signed [SimBits-1:0] similarity;
    logic                      zero_norm;
  } out_req_t;

  typedef struct packed {
    logic [AccBits-1:0] dot;
    logic [AccBits-1:0] norm_a;
    logic [AccBits-1:0] norm_b;
  } acc_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackMul,
    BackSat,
    BackDiv,
    BackRoot,
    BackDone
  } back_state_e;

endpackage

@@ hw/rtl/cosine_similarity_unit.sv @@
// Element pairs are accepted one per cycle and pass through a product register before
// they are summed. When a norm is zero the back end goes straight to its done state;
// otherwise the result comes from the multiply steps and the iterative divider and square
// root. The back end pops a new vector of sums only when idle again after loading its last
// result, and a last pair stalls only while the two-entry queue of sums is full.
// Reset clears the accumulators, the queue and the output valid; no sweep is needed.
module cosine_similarity_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csu_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csu_pkg::out_req_t out_req_o
);
  import csu_pkg::*;

  logic push_valid;
  acc_t push_data;
  logic queue_full;
  logic queue_empty;
  logic pop;
  acc_t pop_data;

  csu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .queue_full_i (queue_full)
  );

  csu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .full_o       (queue_full),
    .empty_o      (queue_empty),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  csu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (~queue_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> !queue_full)
    else $error("push into a full queue");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !queue_empty)
    else $error("pop from an empty queue");

  a_zero_norm_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.zero_norm) |-> (out_req_o.similarity == '0))
    else $error("zero-norm result with nonzero similarity");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> queue_full)
    else $error("input stalled while the queue has room");

endmodule

@@ hw/rtl/csu_front.sv @@
module csu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csu_pkg::in_req_t in_req_i,
  output logic             push_valid_o,
  output csu_pkg::acc_t    push_data_o,
  input  logic             queue_full_i
);
  import csu_pkg::*;

  logic                         p_valid_q;
  logic                         p_last_q;
  logic signed [2*ElemBits-1:0] p_dot_q;
  logic [2*ElemBits-2:0]        p_aa_q;
  logic [2*ElemBits-2:0]        p_bb_q;
  logic signed [2*ElemBits-1:0] mul_ab;
  logic signed [2*ElemBits-1:0] mul_aa;
  logic signed [2*ElemBits-1:0] mul_bb;
  logic [AccBits-1:0]           dot_acc_q;
  logic [AccBits-1:0]           norm_a_acc_q;
  logic [AccBits-1:0]           norm_b_acc_q;
  logic [AccBits-1:0]           dot_sum;
  logic [AccBits-1:0]           norm_a_sum;
  logic [AccBits-1:0]           norm_b_sum;
  logic                         blocked;
  logic                         advance;

  assign mul_ab = $signed(in_req_i.elem_a) * $signed(in_req_i.elem_b);
  assign mul_aa = $signed(in_req_i.elem_a) * $signed(in_req_i.elem_a);
  assign mul_bb = $signed(in_req_i.elem_b) * $signed(in_req_i.elem_b);

  assign dot_sum    = dot_acc_q
                    + {{(AccBits - 2*ElemBits){p_dot_q[2*ElemBits-1]}}, p_dot_q};
  assign norm_a_sum = norm_a_acc_q + {{(AccBits - 2*ElemBits + 1){1'b0}}, p_aa_q};
  assign norm_b_sum = norm_b_acc_q + {{(AccBits - 2*ElemBits + 1){1'b0}}, p_bb_q};

  assign blocked    = p_valid_q & p_last_q & queue_full_i;
  assign advance    = ~blocked;
  assign in_stall_o = blocked;

  assign push_valid_o       = p_valid_q & p_last_q & ~queue_full_i;
  assign push_data_o.dot    = dot_sum;
  assign push_data_o.norm_a = norm_a_sum;
  assign push_data_o.norm_b = norm_b_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q    <= 1'b0;
      p_last_q     <= 1'b0;
      dot_acc_q    <= '0;
      norm_a_acc_q <= '0;
      norm_b_acc_q <= '0;
    end else if (advance) begin
      p_valid_q <= in_valid_i;
      p_last_q  <= in_valid_i & in_req_i.last;
      if (p_valid_q) begin
        if (p_last_q) begin
          dot_acc_q    <= '0;
          norm_a_acc_q <= '0;
          norm_b_acc_q <= '0;
        end else begin
          dot_acc_q    <= dot_sum;
          norm_a_acc_q <= norm_a_sum;
          norm_b_acc_q <= norm_b_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_dot_q <= mul_ab;
      p_aa_q  <= mul_aa[2*ElemBits-2:0];
      p_bb_q  <= mul_bb[2*ElemBits-2:0];
    end
  end

endmodule

@@ hw/rtl/csu_queue.sv @@
module csu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  csu_pkg::acc_t push_data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output csu_pkg::acc_t pop_data_o
);
  import csu_pkg::*;

  acc_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q;
  logic [QPtrBits-1:0] rd_ptr_q;
  logic [QCntBits-1:0] count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (count_q == QCntBits'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_valid_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/csu_back.sv @@
module csu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  csu_pkg::acc_t     q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csu_pkg::out_req_t out_req_o
);
  import csu_pkg::*;

  localparam logic [SimBits-1:0] QmagMax = {1'b1, {(SimBits-1){1'b0}}};
  localparam logic [SimBits-1:0] SimMax  = {1'b0, {(SimBits-1){1'b1}}};

  back_state_e state_q, state_d;
  logic [StepBits-1:0]   step_q;
  logic                  neg_q;
  logic                  zero_q;
  logic [AccBits-1:0]    dmag_q;
  logic [AccBits-1:0]    na_q;
  logic [AccBits-1:0]    nb_q;
  logic [AccBits-1:0]    pp_q;
  logic [2:0]            pp_tag_q;
  logic [ProdBits-1:0]   prod_q;
  logic [ProdBits-1:0]   dsq_q;
  logic [RemBits-1:0]    rem_q;
  logic [RemBits-1:0]    dv_q;
  logic [QuotBits-1:0]   quot_q;
  logic [RootBits-1:0]   sx_q;
  logic [RootBits-1:0]   sres_q;
  logic [RootBits-1:0]   sone_q;
  logic [SimBits-1:0]    qmag_q;
  logic                  out_valid_q;
  out_req_t              out_q;

  logic                  in_zero;
  logic                  in_neg;
  logic [AccBits-1:0]    mul_x;
  logic [AccBits-1:0]    mul_y;
  logic [HalfBits-1:0]   mul_xp;
  logic [HalfBits-1:0]   mul_yp;
  logic [AccBits-1:0]    pp_d;
  logic [ProdBits-1:0]   pp_shifted;
  logic                  sat_cmp;
  logic                  div_ge;
  logic [QuotBits-1:0]   quot_next;
  logic [RootBits-1:0]   root_t;
  logic                  root_ge;
  logic [RootBits-1:0]   sx_nx;
  logic [RootBits-1:0]   sres_nx;
  logic [SimBits-1:0]    sim;
  logic                  out_free;
  logic                  out_load;

  assign in_zero = (q_data_i.norm_a == '0) | (q_data_i.norm_b == '0);
  assign in_neg  = q_data_i.dot[AccBits-1];

  assign mul_x  = step_q[2] ? dmag_q : na_q;
  assign mul_y  = step_q[2] ? dmag_q : nb_q;
  assign mul_xp = step_q[1] ? mul_x[AccBits-1:HalfBits] : mul_x[HalfBits-1:0];
  assign mul_yp = step_q[0] ? mul_y[AccBits-1:HalfBits] : mul_y[HalfBits-1:0];
  assign pp_d   = mul_xp * mul_yp;

  always_comb begin
    case ({1'b0, pp_tag_q[1]} + {1'b0, pp_tag_q[0]})
      2'd0:    pp_shifted = {{AccBits{1'b0}}, pp_q};
      2'd1:    pp_shifted = {{HalfBits{1'b0}}, pp_q, {HalfBits{1'b0}}};
      default: pp_shifted = {pp_q, {AccBits{1'b0}}};
    endcase
  end

  assign sat_cmp   = {1'b0, dsq_q, {(QuotBits-1){1'b0}}} >= {prod_q, {QuotBits{1'b0}}};
  assign div_ge    = rem_q >= dv_q;
  assign quot_next = {quot_q[QuotBits-2:0], div_ge};

  assign root_t  = sres_q + sone_q;
  assign root_ge = sx_q >= root_t;
  assign sx_nx   = root_ge ? sx_q - root_t : sx_q;
  assign sres_nx = root_ge ? (sres_q >> 1) + sone_q : sres_q >> 1;

  always_comb begin
    if (zero_q) begin
      sim = '0;
    end else if (neg_q) begin
      sim = ~qmag_q + 1'b1;
    end else if (qmag_q[SimBits-1]) begin
      sim = SimMax;
    end else begin
      sim = qmag_q;
    end
  end

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: begin
        if (q_valid_i) begin
          state_d = in_zero ? BackDone : BackMul;
        end
      end
      BackMul: begin
        if (step_q == StepBits'(MulSteps)) begin
          state_d = BackSat;
        end
      end
      BackSat: begin
        state_d = sat_cmp ? BackDone : BackDiv;
      end
      BackDiv: begin
        if (step_q == StepBits'(DivSteps - 1)) begin
          state_d = quot_next[QuotBits-1] ? BackDone : BackRoot;
        end
      end
      BackRoot: begin
        if (step_q == StepBits'(RootSteps - 1)) begin
          state_d = BackDone;
        end
      end
      BackDone: begin
        if (out_free) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BackIdle: pop_o    = q_valid_i;
      BackDone: out_load = out_free;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.similarity <= sim;
      out_q.zero_norm  <= zero_q;
    end
    case (state_q)
      BackIdle: begin
        if (q_valid_i) begin
          na_q   <= q_data_i.norm_a;
          nb_q   <= q_data_i.norm_b;
          neg_q  <= in_neg;
          dmag_q <= in_neg ? ~q_data_i.dot + 1'b1 : q_data_i.dot;
          zero_q <= in_zero;
          qmag_q <= '0;
          prod_q <= '0;
          dsq_q  <= '0;
        end
      end
      BackMul: begin
        if (!step_q[3]) begin
          pp_q     <= pp_d;
          pp_tag_q <= step_q[2:0];
        end
        if (step_q != '0) begin
          if (pp_tag_q[2]) begin
            dsq_q <= dsq_q + pp_shifted;
          end else begin
            prod_q <= prod_q + pp_shifted;
          end
        end
      end
      BackSat: begin
        rem_q  <= {dsq_q, {(QuotBits-1){1'b0}}};
        dv_q   <= {prod_q, {(QuotBits-1){1'b0}}};
        quot_q <= '0;
        if (sat_cmp) begin
          qmag_q <= QmagMax;
        end
      end
      BackDiv: begin
        if (div_ge) begin
          rem_q <= rem_q - dv_q;
        end
        dv_q   <= dv_q >> 1;
        quot_q <= quot_next;
        if (step_q == StepBits'(DivSteps - 1)) begin
          sx_q   <= quot_next[RootBits-1:0];
          sres_q <= '0;
          sone_q <= RootBits'(1) << (RootBits - 2);
          if (quot_next[QuotBits-1]) begin
            qmag_q <= QmagMax;
          end
        end
      end
      BackRoot: begin
        sx_q   <= sx_nx;
        sres_q <= sres_nx;
        sone_q <= sone_q >> 2;
        if (step_q == StepBits'(RootSteps - 1)) begin
          qmag_q <= {1'b0, sres_nx[SimBits-2:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ bench/cosine_similarity_unit_checker.sv @@
module cosine_similarity_unit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  csu_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  csu_pkg::out_req_t out_req_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csu_pkg::*;

  logic [AccBits-1:0]          dot_sum;
  logic [AccBits-1:0]          norm_a_sum;
  logic [AccBits-1:0]          norm_b_sum;
  logic signed [2*ElemBits-1:0] prod_ab;
  logic signed [2*ElemBits-1:0] prod_aa;
  logic signed [2*ElemBits-1:0] prod_bb;
  out_req_t                    expected_sim_q[$];
  out_req_t                    want;
  int unsigned                 mismatch_count = 0;
  int unsigned                 pending_count  = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // The largest magnitude q with q*q*na*nb <= 2^30*dot*dot, searched bit by bit.
  function automatic out_req_t cosine_of(input logic [AccBits-1:0] dot,
                                         input logic [AccBits-1:0] na,
                                         input logic [AccBits-1:0] nb);
    logic [AccBits-1:0] dot_mag;
    logic [127:0]       norm_prod;
    logic [127:0]       dot_bound;
    logic [16:0]        qmag;
    logic [16:0]        cand;
    logic [16:0]        qneg;
    logic               neg;
    out_req_t           res;
    res = '0;
    if (na == '0 || nb == '0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    neg       = dot[AccBits-1];
    dot_mag   = neg ? (~dot + 1'b1) : dot;
    norm_prod = 128'(na) * 128'(nb);
    dot_bound = (128'(dot_mag) * 128'(dot_mag)) << 30;
    qmag      = '0;
    for (int bit_pos = 15; bit_pos >= 0; bit_pos--) begin
      cand = qmag | (17'd1 << bit_pos);
      if (cand <= 17'd32768 && norm_prod * 128'(cand) * 128'(cand) <= dot_bound) begin
        qmag = cand;
      end
    end
    if (neg) begin
      qneg = 17'd0 - qmag;
      res.similarity = qneg[SimBits-1:0];
    end else begin
      res.similarity = (qmag > 17'd32767) ? 16'sh7fff : qmag[SimBits-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_sum    = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      expected_sim_q.delete();
      pending_count <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        prod_ab    = $signed(in_req_i.elem_a) * $signed(in_req_i.elem_b);
        prod_aa    = $signed(in_req_i.elem_a) * $signed(in_req_i.elem_a);
        prod_bb    = $signed(in_req_i.elem_b) * $signed(in_req_i.elem_b);
        dot_sum    = dot_sum + {{(AccBits-2*ElemBits){prod_ab[2*ElemBits-1]}}, prod_ab};
        norm_a_sum = norm_a_sum + {{(AccBits-2*ElemBits){1'b0}}, prod_aa};
        norm_b_sum = norm_b_sum + {{(AccBits-2*ElemBits){1'b0}}, prod_bb};
        if (in_req_i.last) begin
          expected_sim_q.insert(expected_sim_q.size(),
                                cosine_of(dot_sum, norm_a_sum, norm_b_sum));
          dot_sum    = '0;
          norm_a_sum = '0;
          norm_b_sum = '0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_sim_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result similarity %0d zero_norm %0b",
                                    out_req_i.similarity, out_req_i.zero_norm));
        end else begin
          want = expected_sim_q.pop_front();
          if (out_req_i.similarity !== want.similarity) begin
            report_mismatch($sformatf("similarity %0d, expected %0d",
                                      out_req_i.similarity, want.similarity));
          end
          if (out_req_i.zero_norm !== want.zero_norm) begin
            report_mismatch($sformatf("zero_norm %0b, expected %0b",
                                      out_req_i.zero_norm, want.zero_norm));
          end
        end
      end
      pending_count <= expected_sim_q.size();
    end
  end

endmodule

@@ bench/cosine_similarity_unit_tb.sv @@
module cosine_similarity_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csu_pkg::*;

  localparam int unsigned                RandomPairs = 1650;
  localparam int unsigned                QuietLimit  = 2000;
  localparam logic signed [ElemBits-1:0] ElemMax     = 16'sh7fff;
  localparam logic signed [ElemBits-1:0] ElemMin     = 16'sh8000;

  typedef enum int unsigned {
    MixFull,
    MixEqual,
    MixOpposite,
    MixZeroA,
    MixZeroB,
    MixTiny,
    MixCorner,
    MixScaled
  } vec_mix_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_req_t     in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_req_t    out_req;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned pairs_sent      = 0;
  int unsigned idle_pct        = 0;
  int unsigned idle_items_left = 0;
  int unsigned stall_pct       = 0;
  int unsigned stall_cycles    = 0;
  int unsigned stall_run       = 0;
  int unsigned quiet_cycles    = 0;

  cosine_similarity_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  cosine_similarity_unit_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_cycles == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
      stall_cycles = $urandom_range(100, 400);
    end else begin
      stall_cycles--;
    end
    if (stall_run == 0) begin
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      stall_run--;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_pair(input logic signed [ElemBits-1:0] ea,
                           input logic signed [ElemBits-1:0] eb,
                           input logic is_last, input logic may_idle);
    int unsigned gap;
    in_req_t     req;
    gap = 0;
    if (may_idle) begin
      if (idle_items_left == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
        idle_items_left = $urandom_range(20, 80);
      end else begin
        idle_items_left--;
      end
      if ($urandom_range(0, 99) < idle_pct) begin
        gap = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.elem_a = ea;
    req.elem_b = eb;
    req.last   = is_last;
    in_req   <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
  endtask

  function automatic logic signed [ElemBits-1:0] corner_elem();
    case ($urandom_range(0, 4))
      0:       return ElemMin;
      1:       return ElemMax;
      2:       return '0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  task automatic send_vector(input int unsigned len, input vec_mix_e mix);
    logic signed [ElemBits-1:0] ea;
    logic signed [ElemBits-1:0] eb;
    int unsigned                shift;
    shift = $urandom_range(0, 6);
    for (int unsigned k = 0; k < len; k++) begin
      ea = ElemBits'($urandom);
      eb = ElemBits'($urandom);
      case (mix)
        MixEqual:    eb = ea;
        MixOpposite: eb = -ea;
        MixZeroA:    ea = '0;
        MixZeroB:    eb = '0;
        MixTiny: begin
          ea = ElemBits'(int'($urandom_range(0, 6)) - 3);
          eb = ElemBits'(int'($urandom_range(0, 6)) - 3);
        end
        MixCorner: begin
          ea = corner_elem();
          eb = corner_elem();
        end
        MixScaled:   eb = ea >>> shift;
        default:     ;
      endcase
      send_pair(ea, eb, k == len - 1, 1'b1);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_pair(ElemMax, ElemMax, 1'b1, 1'b1);
    send_pair(ElemMin, ElemMax, 1'b1, 1'b1);
    send_pair(ElemMin, ElemMin, 1'b1, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b1, 1'b1);
    send_pair(16'sd7, 16'sd0, 1'b1, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0, 1'b1);
    send_pair(16'sd0, 16'sd1, 1'b1, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b1, 1'b1);
    send_pair(16'sd1, 16'sd3, 1'b0, 1'b1);
    send_pair(16'sd2, -16'sd1, 1'b1, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0, 1'b1);
    send_pair(ElemMax, ElemMin, 1'b0, 1'b1);
    send_pair(ElemMin, ElemMax, 1'b1, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0, 1'b1);
    send_pair(16'sd3, -16'sd3, 1'b1, 1'b1);

    while (pairs_sent < RandomPairs) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 6);
      end else if (pick < 95) begin
        len = $urandom_range(7, 32);
      end else begin
        len = $urandom_range(33, 120);
      end
      pick = $urandom_range(0, 99);
      send_vector(len, (pick < 30) ? MixFull : vec_mix_e'(pick % 8));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ cosine_similarity_unit.f @@
hw/rtl/csu_pkg.sv
hw/rtl/csu_front.sv
hw/rtl/csu_queue.sv
hw/rtl/csu_back.sv
hw/rtl/cosine_similarity_unit.sv
bench/cosine_similarity_unit_checker.sv
bench/cosine_similarity_unit_tb.sv
